// ===== sv/u16sc_pkg.sv =====
// Shared types, constants and the UTF-8 byte builder of the UTF-16 to UTF-8
// space-collapsing transcoder. Depends on nothing; imported by every module.
package u16sc_pkg;

  // depth of the job queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned LimitW = 24;
  localparam logic [LimitW-1:0] LimitReset = 24'h010000;

  localparam logic [7:0]  SpaceByte  = 8'h20;
  localparam logic [15:0] HighSurLo  = 16'hd800;
  localparam logic [15:0] HighSurHi  = 16'hdbff;
  localparam logic [15:0] LowSurLo   = 16'hdc00;
  localparam logic [15:0] LowSurHi   = 16'hdfff;
  localparam logic [20:0] SuppBase   = 21'h010000;

  // one code point to be written, with an optional leading space
  typedef struct packed {
    logic        vld;   // code point is written
    logic        sp;    // a 0x20 byte goes before it
    logic [20:0] cp;
    logic [2:0]  w;     // utf-8 length, 1 to 4
  } seg_t;

  // everything one accepted code unit causes
  typedef struct packed {
    seg_t a;      // unpaired held surrogate, if any
    seg_t b;      // code point of the unit itself
    logic eot;
    logic over;
  } job_t;

  // number of output bytes of a segment
  function automatic logic [2:0] seg_len(seg_t s);
    return s.vld ? (s.w + {2'b00, s.sp}) : 3'd0;
  endfunction

  // byte idx of the utf-8 encoding of cp, w bytes long
  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] w, logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (w)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          2'd3: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== sv/u16sc_front.sv =====
// Front part: takes code units, pairs surrogates, classifies whitespace and
// checks the byte limit, then pushes a job for each unit that yields output or ends a text. Uses u16sc_pkg.
module u16sc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [23:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic [15:0]               in_data_i,
  input  logic                      in_last_i,
  output logic                      in_ready_o,
  input  logic                      q_full_i,
  output logic                      push_o,
  output u16sc_pkg::job_t           job_o
);
  import u16sc_pkg::*;

  typedef struct packed {
    seg_t              seg;
    logic              sp;
    logic              any;
    logic [LimitW-1:0] cnt;
    logic              hit;
  } take_t;

  function automatic logic is_space(logic [20:0] cp);
    return (cp >= 21'h09 && cp <= 21'h0d) || cp == 21'h20 || cp == 21'h85 ||
           cp == 21'ha0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200a) ||
           cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202f ||
           cp == 21'h205f || cp == 21'h3000;
  endfunction

  function automatic logic [2:0] width_of(logic [20:0] cp);
    return (cp < 21'h80) ? 3'd1 : ((cp < 21'h800) ? 3'd2 : ((cp < 21'h10000) ? 3'd3 : 3'd4));
  endfunction

  // one code point against the running text state
  function automatic take_t take_cp(logic [20:0] cp, logic hit, logic sp, logic any,
                                    logic [LimitW-1:0] cnt, logic [LimitW-1:0] maxb);
    take_t       r;
    logic [24:0] nxt;
    logic [2:0]  w;
    w          = width_of(cp);
    r.seg.vld  = 1'b0;
    r.seg.sp   = 1'b0;
    r.seg.cp   = cp;
    r.seg.w    = w;
    r.sp       = sp;
    r.any      = any;
    r.cnt      = cnt;
    r.hit      = hit;
    nxt        = {1'b0, cnt} + {24'd0, sp} + {22'd0, w};
    if (!hit) begin
      if (is_space(cp)) begin
        if (any) r.sp = 1'b1;
      end else if (nxt > {1'b0, maxb}) begin
        r.hit = 1'b1;
      end else begin
        r.seg.vld = 1'b1;
        r.seg.sp  = sp;
        r.sp      = 1'b0;
        r.cnt     = nxt[LimitW-1:0];
        r.any     = 1'b1;
      end
    end
    return r;
  endfunction

  logic [LimitW-1:0] max_q;
  logic [15:0]       held_high_q, held_high_d;
  logic              held_valid_q, held_valid_d;
  logic              space_q, space_d;
  logic              any_q, any_d;
  logic [LimitW-1:0] cnt_q, cnt_d;
  logic              hit_q, hit_d;
  logic              pend_q, pend_d;
  logic [15:0]       pend_cu_q, pend_cu_d;
  logic              pend_last_q, pend_last_d;
  seg_t              slot_a_q, slot_a_d;

  logic [15:0] unit;
  logic        last;
  logic        go, is_low, is_high, combine, split, hold;
  logic [20:0] cp_sel;
  take_t       tk;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= LimitReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // select the unit and code point of this cycle
  always_comb begin
    unit    = pend_q ? pend_cu_q : in_data_i;
    last    = pend_q ? pend_last_q : in_last_i;
    is_low  = (unit >= LowSurLo) && (unit <= LowSurHi);
    is_high = (unit >= HighSurLo) && (unit <= HighSurHi);
    combine = !pend_q && held_valid_q && is_low;
    split   = !pend_q && held_valid_q && !is_low;
    hold    = !combine && !split && is_high && !last;
    in_ready_o = !pend_q && !q_full_i;
    go      = pend_q ? !q_full_i : (in_valid_i && in_ready_o);
    if (combine) begin
      cp_sel = {1'b0, held_high_q[9:0], unit[9:0]} + SuppBase;
    end else if (split) begin
      cp_sel = {5'd0, held_high_q};
    end else begin
      cp_sel = {5'd0, unit};
    end
    tk = take_cp(cp_sel, hit_q, space_q, any_q, cnt_q, max_q);
    if (hold) begin
      tk.seg.vld = 1'b0;
      tk.sp      = space_q;
      tk.any     = any_q;
      tk.cnt     = cnt_q;
      tk.hit     = hit_q;
    end
  end

  // state update and job assembly
  always_comb begin
    held_high_d  = held_high_q;
    held_valid_d = held_valid_q;
    space_d      = space_q;
    any_d        = any_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    pend_d       = pend_q;
    pend_cu_d    = pend_cu_q;
    pend_last_d  = pend_last_q;
    slot_a_d     = slot_a_q;
    push_o       = 1'b0;
    job_o.a      = pend_q ? slot_a_q : '0;
    job_o.b      = tk.seg;
    job_o.eot    = last;
    job_o.over   = last && tk.hit;
    if (go) begin
      space_d = tk.sp;
      any_d   = tk.any;
      cnt_d   = tk.cnt;
      hit_d   = tk.hit;
      if (split) begin
        // lone held surrogate now, the new unit from the pending register once the queue has room
        slot_a_d     = tk.seg;
        pend_d       = 1'b1;
        pend_cu_d    = unit;
        pend_last_d  = last;
        held_valid_d = 1'b0;
        held_high_d  = '0;
      end else begin
        pend_d       = 1'b0;
        held_valid_d = hold;
        held_high_d  = hold ? unit : '0;
        push_o       = job_o.a.vld || job_o.b.vld || last;
        if (last) begin
          held_valid_d = 1'b0;
          held_high_d  = '0;
          space_d      = 1'b0;
          any_d        = 1'b0;
          cnt_d        = '0;
          hit_d        = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_high_q  <= '0;
      space_q      <= 1'b0;
      any_q        <= 1'b0;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      held_high_q  <= held_high_d;
      space_q      <= space_d;
      any_q        <= any_d;
      cnt_q        <= cnt_d;
      hit_q        <= hit_d;
      pend_q       <= pend_d;
    end
  end

  // payload of the deferred unit
  always_ff @(posedge clk_i) begin
    pend_cu_q   <= pend_cu_d;
    pend_last_q <= pend_last_d;
    slot_a_q    <= slot_a_d;
  end

endmodule

// ===== sv/u16sc_queue.sv =====
// Short job queue that decouples the front from the back.
// Depends on u16sc_pkg for the job type and depth.
module u16sc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16sc_pkg::job_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output u16sc_pkg::job_t head_o
);
  import u16sc_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth)) else $error("queue count beyond depth");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("pointers differ when empty");

endmodule

// ===== sv/u16sc_back.sv =====
// Back part: walks each job byte by byte and drives the output register.
// Depends on u16sc_pkg for the job type and the utf-8 byte builder.
module u16sc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  u16sc_pkg::job_t job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            end_of_text_o,
  output logic            over_limit_o
);
  import u16sc_pkg::*;

  logic       seg_q, seg_d;
  logic [2:0] pos_q, pos_d;
  logic       ov_q;
  logic [7:0] byte_q;
  logic       bv_q, eot_q, over_q;

  logic [2:0] n_a, n_b, n_cur;
  logic       eff_b, bare, last_in, seg_end, load;
  seg_t       cur;
  logic [1:0] idx;
  logic [7:0] byte_c;

  // current byte of the head job
  always_comb begin
    n_a     = seg_len(job_i.a);
    n_b     = seg_len(job_i.b);
    eff_b   = seg_q || (n_a == 3'd0);
    cur     = eff_b ? job_i.b : job_i.a;
    n_cur   = eff_b ? n_b : n_a;
    bare    = (n_a == 3'd0) && (n_b == 3'd0);
    seg_end = (pos_q == n_cur - 3'd1);
    last_in = bare || (eff_b ? seg_end : (seg_end && (n_b == 3'd0)));
    idx     = 2'(pos_q - {2'b00, cur.sp});
    if (bare) begin
      byte_c = 8'h00;
    end else if (cur.sp && pos_q == 3'd0) begin
      byte_c = SpaceByte;
    end else begin
      byte_c = utf8_byte(cur.cp, cur.w, idx);
    end
    load  = q_valid_i && (!ov_q || out_ready_i);
    pop_o = load && last_in;
    seg_d = seg_q;
    pos_d = pos_q;
    if (load) begin
      if (last_in) begin
        seg_d = 1'b0;
        pos_d = 3'd0;
      end else if (seg_end) begin
        seg_d = 1'b1;
        pos_d = 3'd0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  // walk position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= 1'b0;
      pos_q <= 3'd0;
      ov_q  <= 1'b0;
    end else begin
      seg_q <= seg_d;
      pos_q <= pos_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_c;
      bv_q   <= !bare;
      eot_q  <= last_in && job_i.eot;
      over_q <= last_in && job_i.eot && job_i.over;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bv_q;
  assign end_of_text_o = eot_q;
  assign over_limit_o  = over_q;

endmodule

// ===== sv/utf16_to_utf8_space_collapser.sv =====
// UTF-16 to UTF-8 transcoder with whitespace collapsing and a byte limit.
// The first byte of a code unit passes through the job queue and the output register before it is valid on m_axis.
// Throughput: one output byte per cycle while jobs are queued and m_axis is not stalled; a unit yields up to 7 bytes;
// a unit after an unpaired high surrogate is deferred in the front, which takes no new unit meanwhile.
// Reset: asynchronous, clears all text state and the queue, max_bytes returns to 65536.
// Depends on u16sc_pkg, u16sc_front, u16sc_queue and u16sc_back.
module utf16_to_utf8_space_collapser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,     // max_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [15:0] code_unit
  input  logic        s_axis_tlast,    // last_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,    // [0] byte_valid, [1] over_limit
  output logic        m_axis_tlast     // end_of_text
);
  import u16sc_pkg::*;

  logic q_full, q_empty, push, pop;
  job_t push_job, head_job;
  logic byte_valid, over_limit;

  // classification and limit check
  u16sc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // job queue
  u16sc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  // byte serializer
  u16sc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (!q_empty),
    .job_i         (head_job),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .byte_valid_o  (byte_valid),
    .end_of_text_o (m_axis_tlast),
    .over_limit_o  (over_limit)
  );

  assign m_axis_tuser = {over_limit, byte_valid};

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the UTF-16 to UTF-8 space-collapsing transcoder.
// Feeds texts of code units, predicts the byte stream and compares each result.
// Depends on u16sc_pkg and utf16_to_utf8_space_collapser.
module tb_top;
  import u16sc_pkg::*;

  // one code unit on the input stream
  typedef struct packed {
    logic [15:0] cu;
    logic        last;
  } unit_t;

  // one byte or end marker on the output stream
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eot;
    logic       over;
  } utf8_res_t;

  localparam int HoldPhase  = 3;
  localparam int HoldCycles = 300;
  localparam int Settle     = 10;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [LimitW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;

  utf16_to_utf8_space_collapser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  unit_t     pending_units[$];
  utf8_res_t expected_bytes[$];

  int phase_no = 0;
  bit quiet = 1'b0;
  int errors = 0;
  int units_sent = 0;
  int texts_sent = 0;
  int bytes_seen = 0;
  int ends_seen = 0;
  int over_seen = 0;
  int limits_used = 0;

  // predictor state
  logic [LimitW-1:0] byte_limit = LimitReset;
  logic [15:0]       pend_high = '0;
  logic              pend_high_vld = 1'b0;
  logic              space_owed = 1'b0;
  logic              seen_nonspace = 1'b0;
  logic [24:0]       text_bytes = '0;
  logic              over_flag = 1'b0;

  function automatic logic is_unicode_space(logic [20:0] cp);
    return (cp >= 21'h09 && cp <= 21'h0d) || cp == 21'h20 || cp == 21'h85 ||
           cp == 21'ha0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200a) ||
           cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202f ||
           cp == 21'h205f || cp == 21'h3000;
  endfunction

  function automatic logic [2:0] cp_enc_len(logic [20:0] cp);
    if (cp < 21'h80) return 3'd1;
    if (cp < 21'h800) return 3'd2;
    if (cp < 21'h10000) return 3'd3;
    return 3'd4;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    utf8_res_t r;
    r = '{data: b, valid: 1'b1, eot: 1'b0, over: 1'b0};
    expected_bytes.push_back(r);
  endfunction

  function automatic void encode_code_point(logic [20:0] cp);
    case (cp_enc_len(cp))
      3'd1: emit_byte(cp[7:0]);
      3'd2: begin
        emit_byte(8'hc0 | {3'b000, cp[10:6]});
        emit_byte(8'h80 | {2'b00, cp[5:0]});
      end
      3'd3: begin
        emit_byte(8'he0 | {4'h0, cp[15:12]});
        emit_byte(8'h80 | {2'b00, cp[11:6]});
        emit_byte(8'h80 | {2'b00, cp[5:0]});
      end
      default: begin
        emit_byte(8'hf0 | {5'b00000, cp[20:18]});
        emit_byte(8'h80 | {2'b00, cp[17:12]});
        emit_byte(8'h80 | {2'b00, cp[11:6]});
        emit_byte(8'h80 | {2'b00, cp[5:0]});
      end
    endcase
  endfunction

  // apply one code point to the collapsing and limit logic
  function automatic void take_code_point(logic [20:0] cp);
    logic [24:0] next_count;
    if (over_flag) return;
    if (is_unicode_space(cp)) begin
      if (seen_nonspace) space_owed = 1'b1;
      return;
    end
    next_count = text_bytes + 25'(space_owed) + 25'(cp_enc_len(cp));
    if (next_count > {1'b0, byte_limit}) begin
      over_flag = 1'b1;
      return;
    end
    if (space_owed) emit_byte(8'h20);
    space_owed = 1'b0;
    encode_code_point(cp);
    text_bytes = next_count;
    seen_nonspace = 1'b1;
  endfunction

  // expected results of one accepted code unit
  function automatic void predict_unit(logic [15:0] cu, logic last);
    int        n0;
    logic      fresh;
    utf8_res_t r;
    n0 = expected_bytes.size();
    fresh = 1'b1;
    if (pend_high_vld) begin
      if (cu >= 16'hdc00 && cu <= 16'hdfff) begin
        take_code_point(21'h10000 + {1'b0, pend_high[9:0], cu[9:0]});
        fresh = 1'b0;
      end else begin
        take_code_point({5'b0, pend_high});
      end
      pend_high_vld = 1'b0;
      pend_high = '0;
    end
    if (fresh) begin
      if (cu >= 16'hd800 && cu <= 16'hdbff && !last) begin
        pend_high = cu;
        pend_high_vld = 1'b1;
      end else begin
        take_code_point({5'b0, cu});
      end
    end
    if (last) begin
      if (expected_bytes.size() == n0) begin
        r = '{data: 8'h00, valid: 1'b0, eot: 1'b1, over: over_flag};
      end else begin
        r = expected_bytes.pop_back();
        r.eot = 1'b1;
        r.over = over_flag;
      end
      expected_bytes.push_back(r);
      pend_high = '0;
      pend_high_vld = 1'b0;
      space_owed = 1'b0;
      seen_nonspace = 1'b0;
      text_bytes = '0;
      over_flag = 1'b0;
      texts_sent++;
    end
  endfunction

  // input side: predict on each transaction, then offer the next unit or idle
  int tx_gap = 0;
  always @(posedge clk_i) begin : tx_side
    unit_t u;
    logic  next_valid;
    if (rst_ni) begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_unit(s_axis_tdata, s_axis_tlast);
        units_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_units.size() != 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(1, 7) - 1;
          end else begin
            u = pending_units.pop_front();
            s_axis_tdata <= u.cu;
            s_axis_tlast <= u.last;
            next_valid = 1'b1;
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // output side: check each transaction against the oldest expected byte
  int rx_stall = 0;
  bit rx_hold_done = 1'b0;
  always @(posedge clk_i) begin : rx_side
    utf8_res_t want;
    logic      next_ready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tuser[0]) bytes_seen++;
        if (m_axis_tlast) ends_seen++;
        if (m_axis_tlast && m_axis_tuser[1]) over_seen++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %02h byte_valid %b end_of_text %b",
                 m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser[0] !== want.valid) begin
            $error("byte_valid: expected %b, got %b", want.valid, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tlast !== want.eot) begin
            $error("end_of_text: expected %b, got %b", want.eot, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser[1] !== want.over) begin
            $error("over_limit: expected %b, got %b", want.over, m_axis_tuser[1]);
            errors++;
          end
        end
      end
      // long hold once so the block fills and stalls its input
      if (phase_no == HoldPhase && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        rx_stall = HoldCycles;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        next_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(1, 7) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  // queue one code unit
  task automatic add_unit(logic [15:0] cu, logic last);
    unit_t u;
    u = '{cu: cu, last: last};
    pending_units.push_back(u);
  endtask

  function automatic logic [15:0] pick_space();
    case ($urandom_range(0, 9))
      0: return 16'h0009 + 16'($urandom_range(0, 4));
      1: return 16'h0020;
      2: return 16'h0085;
      3: return 16'h00a0;
      4: return 16'h1680;
      5: return 16'h2000 + 16'($urandom_range(0, 10));
      6: return ($urandom_range(0, 1) != 0) ? 16'h2028 : 16'h2029;
      7: return 16'h202f;
      8: return 16'h205f;
      default: return 16'h3000;
    endcase
  endfunction

  // one random text of roughly len units, mostly well formed
  task automatic gen_text(int len, inout int added);
    int    n;
    int    k;
    unit_t u;
    n = 0;
    while (n < len) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        add_unit(16'($urandom_range(16'h21, 16'h7e)), 1'b0);
      end else if (k < 50) begin
        add_unit(pick_space(), 1'b0);
      end else if (k < 60) begin
        add_unit(16'($urandom_range(16'h80, 16'h7ff)), 1'b0);
      end else if (k < 70) begin
        if ($urandom_range(0, 1) != 0) add_unit(16'($urandom_range(16'h800, 16'hd7ff)), 1'b0);
        else add_unit(16'($urandom_range(16'he000, 16'hffff)), 1'b0);
      end else if (k < 82) begin
        add_unit(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
        add_unit(16'($urandom_range(16'hdc00, 16'hdfff)), 1'b0);
        n++;
      end else if (k < 88) begin
        add_unit(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
      end else if (k < 93) begin
        add_unit(16'($urandom_range(16'hdc00, 16'hdfff)), 1'b0);
      end else begin
        add_unit(16'($urandom_range(0, 16'hffff)), 1'b0);
      end
      n++;
    end
    u = pending_units.pop_back();
    u.last = 1'b1;
    pending_units.push_back(u);
    added += n;
  endtask

  task automatic gen_phase(int units);
    int added;
    added = 0;
    while (added < units) gen_text($urandom_range(1, 12), added);
  endtask

  // wait until every unit is taken and every result is back, then let it settle
  task automatic drain();
    @(negedge clk_i);
    while (pending_units.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    byte_limit = v;
    limits_used++;
  endtask

  // stimulus sequence
  initial begin : stim
    logic [LimitW-1:0] rnd_limits[6];
    int                wait_cnt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    limits_used = 1;

    // leading, inner and trailing spaces, in a text ending on a space
    add_unit(16'h0020, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'h3000, 1'b0);
    add_unit(16'h1680, 1'b0);
    add_unit(16'h00e9, 1'b0);
    add_unit(16'h2028, 1'b1);
    // surrogate pair
    add_unit(16'hd83d, 1'b0);
    add_unit(16'hde00, 1'b1);
    // unpaired high, lone low, high surrogate on the last unit
    add_unit(16'hd800, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'hdc00, 1'b0);
    add_unit(16'hdbff, 1'b1);
    // width boundaries and field extremes
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007f, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07ff, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hffff, 1'b1);
    // text of spaces only
    add_unit(16'h0009, 1'b1);
    drain();

    // limit passed on an owed space
    phase_no = 1;
    write_limit(24'd3);
    add_unit(16'h0061, 1'b0);
    add_unit(16'h0062, 1'b0);
    add_unit(16'h0020, 1'b0);
    add_unit(16'h0063, 1'b0);
    add_unit(16'h0064, 1'b1);
    drain();

    // zero limit
    phase_no = 2;
    write_limit(24'd0);
    add_unit(16'h0078, 1'b1);
    add_unit(16'h0020, 1'b0);
    add_unit(16'h0079, 1'b1);
    drain();

    // random phases over several limits
    rnd_limits[0] = 24'hffffff;
    rnd_limits[1] = 24'd1;
    rnd_limits[2] = 24'($urandom_range(2, 12));
    rnd_limits[3] = 24'($urandom_range(13, 60));
    rnd_limits[4] = LimitReset;
    rnd_limits[5] = 24'($urandom_range(1, 24'hffffff));
    for (int p = 0; p < 6; p++) begin
      phase_no = HoldPhase + p;
      quiet = (p == 5);
      write_limit(rnd_limits[p]);
      gen_phase(36);
      if (p < 5) drain();
    end

    // final drain with a bound so leftovers are reported
    wait_cnt = 0;
    @(negedge clk_i);
    while ((pending_units.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
           && wait_cnt < 20000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (Settle) @(negedge clk_i);
    if (expected_bytes.size() != 0) begin
      $error("%0d expected results never arrived", expected_bytes.size());
      errors++;
    end

    $display("covered %0d code units in %0d texts over %0d limit settings",
             units_sent, texts_sent, limits_used);
    $display("checked %0d bytes and %0d end markers, %0d texts over the limit",
             bytes_seen, ends_seen, over_seen);
    if (errors == 0) begin
      $display("utf16_to_utf8_space_collapser test passed");
    end else begin
      $display("utf16_to_utf8_space_collapser test failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2000000;
    $display("utf16_to_utf8_space_collapser test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/u16sc_pkg.sv
sv/u16sc_front.sv
sv/u16sc_queue.sv
sv/u16sc_back.sv
sv/utf16_to_utf8_space_collapser.sv
sim/tb_top.sv
